// File: hw/rtl/kpq_pkg.sv
// Package: shared types, constants and the command struct for the pose block
`timescale 1ns / 1ps
package kpq_pkg;
    localparam int KeyW   = 12;
    localparam int DtW    = 20;
    localparam int RateW  = 24;
    localparam int AngW   = 24;
    localparam int PosW   = 32;
    localparam int QW     = 16;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_ROT_RATE   = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_TRANS_RATE = 1'b1;

    localparam logic [RateW-1:0] ROT_RATE_RST   = 24'd1335089;
    localparam logic [RateW-1:0] TRANS_RATE_RST = 24'd65536;

    localparam logic [31:0] SIN_A = 32'd1686629713;
    localparam logic [31:0] SIN_B = 32'd688904866;
    localparam logic [31:0] SIN_C = 32'd76016977;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INC,      // compute both increments
        OP_UPDATE,   // step angles and positions
        OP_TRIG_LD,  // load phase for trig slot
        OP_SQ,       // x2 = x*x >> 30
        OP_T1,       // t = B - (C*x2 >> 30)
        OP_T2,       // t = A - (x2*t >> 30)
        OP_T3,       // t = x*t >> 30, round, sign, store slot
        OP_PROD1,    // pair products for quaternion term
        OP_PROD2,    // triple products, sum, round, store
        OP_OUT       // latch result item
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] slot;   // trig slot 0..5 or quat part 0..3
    } cmd_t;
endpackage

// File: hw/rtl/kpq_if.sv
// Interfaces: input and result channels
`timescale 1ns / 1ps
interface kpq_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] keys_held;
    logic [19:0] delta_t;
    modport source (output valid, keys_held, delta_t, input ready);
    modport sink   (input valid, keys_held, delta_t, output ready);
endinterface

interface kpq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    output ready);
endinterface

// File: hw/rtl/keyed_pose_to_quaternion.sv
// Top level: keyed pose integrator with quaternion output
//
// channel  dir  handshake     payload
// in       in   valid/ready   keys_held[11:0], delta_t[19:0]
// out      out  valid/ready   pos_x/y/z[31:0], quat_w/x/y/z[15:0]
// cfg      in   cfg_we        cfg_index[0], cfg_data[23:0]
//
// An item runs from accept to result valid through increments, update,
// then six passes through the one shared sine multiplier,
// four quaternion terms and the output latch. A new item is accepted only
// once the controller is idle again and the last result has been taken.
// Reset clears angles, positions and rates to defaults; no clearing pass.
// A waiting result holds the input off until it is taken.
`timescale 1ns / 1ps
module keyed_pose_to_quaternion (
    input  logic        clk,
    input  logic        rst_n,
    kpq_in_if.sink      in_ch,
    kpq_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [kpq_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [23:0] cfg_data
);
    import kpq_pkg::*;

    logic [RateW-1:0] rot_rate_reg, trans_rate_reg;
    cmd_t             cmd;
    logic             in_take;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_rate_reg   <= ROT_RATE_RST;
            trans_rate_reg <= TRANS_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROT_RATE:   rot_rate_reg   <= cfg_data;
                CFG_TRANS_RATE: trans_rate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_take = in_ch.valid && in_ch.ready;

    kpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    kpq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_take    (in_take),
        .keys_held  (in_ch.keys_held),
        .delta_t    (in_ch.delta_t),
        .rot_rate   (rot_rate_reg),
        .trans_rate (trans_rate_reg),
        .pos_x      (out_ch.pos_x),
        .pos_y      (out_ch.pos_y),
        .pos_z      (out_ch.pos_z),
        .quat_w     (out_ch.quat_w),
        .quat_x     (out_ch.quat_x),
        .quat_y     (out_ch.quat_y),
        .quat_z     (out_ch.quat_z)
    );

    // no new item while a result waits
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input ready with result pending");
    // an accepted item starts the sequence
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> cmd.op == OP_INC) else $error("accept did not start increment");
    // result appears only after the output op
    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.op == OP_OUT)) else $error("stray result");
endmodule

// File: hw/rtl/kpq_ctrl.sv
// Controller: sequences one item through the datapath
`timescale 1ns / 1ps
module kpq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output kpq_pkg::cmd_t cmd
);
    import kpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INC, S_UPD, S_LD, S_SQ, S_T1, S_T2, S_T3, S_P1, S_P2, S_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] slot_reg;
    logic       out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.slot = slot_reg;
        unique case (state_reg)
            S_INC:   cmd.op = OP_INC;
            S_UPD:   cmd.op = OP_UPDATE;
            S_LD:    cmd.op = OP_TRIG_LD;
            S_SQ:    cmd.op = OP_SQ;
            S_T1:    cmd.op = OP_T1;
            S_T2:    cmd.op = OP_T2;
            S_T3:    cmd.op = OP_T3;
            S_P1:    cmd.op = OP_PROD1;
            S_P2:    cmd.op = OP_PROD2;
            S_OUT:   cmd.op = OP_OUT;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                        state_reg <= S_INC;
                S_INC: state_reg <= S_UPD;
                S_UPD:
                begin
                    slot_reg  <= '0;
                    state_reg <= S_LD;
                end
                S_LD: state_reg <= S_SQ;
                S_SQ: state_reg <= S_T1;
                S_T1: state_reg <= S_T2;
                S_T2: state_reg <= S_T3;
                S_T3:
                    if (slot_reg == 3'd5)
                    begin
                        slot_reg  <= '0;
                        state_reg <= S_P1;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 3'd1;
                        state_reg <= S_LD;
                    end
                S_P1: state_reg <= S_P2;
                S_P2:
                    if (slot_reg == 3'd3)
                        state_reg <= S_OUT;
                    else
                    begin
                        slot_reg  <= slot_reg + 3'd1;
                        state_reg <= S_P1;
                    end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/kpq_datapath.sv
// Datapath: state registers, shared quarter-wave sine unit and quaternion products
`timescale 1ns / 1ps
module kpq_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kpq_pkg::cmd_t        cmd,
    input  logic                 in_take,
    input  logic [11:0]          keys_held,
    input  logic [19:0]          delta_t,
    input  logic [23:0]          rot_rate,
    input  logic [23:0]          trans_rate,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   pos_z,
    output logic signed [15:0]   quat_w,
    output logic signed [15:0]   quat_x,
    output logic signed [15:0]   quat_y,
    output logic signed [15:0]   quat_z
);
    import kpq_pkg::*;

    logic [KeyW-1:0]        keys_reg;
    logic [DtW-1:0]         dt_reg;
    logic [AngW-1:0]        ang_reg [3];     // yaw, pitch, roll
    logic signed [PosW-1:0] pos_reg [3];     // x, y, z
    logic [23:0]            ainc_reg, pinc_reg;
    // trig slots: 0 cy,1 sy,2 cr,3 sr,4 cp,5 sp
    logic signed [15:0]     trig_reg [6];
    logic [31:0]            x_reg, x2_reg, t_reg;
    logic                   neg_reg;
    logic signed [29:0]     pa_reg, pb_reg;
    logic signed [15:0]     qa_reg, qb_reg;
    logic signed [QW-1:0]   q_reg [4];       // w, x, y, z
    logic signed [QW-1:0]   qo_reg [4];
    logic signed [PosW-1:0] po_reg [3];

    function automatic logic [AngW-1:0] step_ang(input logic [AngW-1:0] a,
            input logic up, input logic dn, input logic [23:0] inc);
        if (up && !dn)      return a + inc;
        else if (dn && !up) return a - inc;
        else                return a;
    endfunction

    function automatic logic signed [PosW-1:0] step_pos(input logic signed [PosW-1:0] p,
            input logic up, input logic dn, input logic [23:0] inc);
        logic signed [PosW:0] v;
        v = {p[PosW-1], p};
        if (up && !dn)      v = v + $signed({9'd0, inc});
        else if (dn && !up) v = v - $signed({9'd0, inc});
        if (v[PosW] != v[PosW-1])
            return v[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        return v[PosW-1:0];
    endfunction

    // phase for the current trig slot: even slots are cosines
    logic [1:0]      ang_sel;
    logic [AngW-1:0] phase;
    logic [21:0]     r;
    logic [22:0]     u;
    always_comb
    begin
        ang_sel = 2'd0;
        unique case (cmd.slot)
            3'd0, 3'd1: ang_sel = 2'd0;
            3'd2, 3'd3: ang_sel = 2'd2;
            3'd4, 3'd5: ang_sel = 2'd1;
            default:    ang_sel = 2'd0;
        endcase
        phase = ang_reg[ang_sel] + (cmd.slot[0] ? 24'd0 : 24'h400000);
        r = phase[21:0];
        u = phase[22] ? (23'h400000 - {1'b0, r}) : {1'b0, r};
    end

    // quaternion term operands: a*b*c + s*(d*e*f)
    logic [2:0] i1, i2, i3, i4, i5, i6;
    logic       sub;
    always_comb
    begin
        unique case (cmd.slot[1:0])
            2'd0: begin i1=3'd0; i2=3'd2; i3=3'd4; i4=3'd1; i5=3'd3; i6=3'd5; sub=1'b0; end // w
            2'd1: begin i1=3'd0; i2=3'd3; i3=3'd4; i4=3'd1; i5=3'd2; i6=3'd5; sub=1'b1; end // x
            2'd2: begin i1=3'd0; i2=3'd2; i3=3'd5; i4=3'd1; i5=3'd3; i6=3'd4; sub=1'b0; end // y
            default: begin i1=3'd1; i2=3'd2; i3=3'd4; i4=3'd0; i5=3'd3; i6=3'd5; sub=1'b1; end // z
        endcase
    end

    logic [63:0]        m;
    logic signed [44:0] s1, s2, ssum;
    logic signed [45:0] sr;
    logic signed [17:0] qv;
    logic signed [QW-1:0] qc;
    logic [43:0]        rinc, tinc;
    always_comb
    begin
        m    = '0;
        s1   = '0;
        s2   = '0;
        ssum = '0;
        sr   = '0;
        qv   = '0;
        qc   = '0;
        rinc = {20'd0, rot_rate} * {24'd0, dt_reg};
        tinc = {20'd0, trans_rate} * {24'd0, dt_reg};
        unique case (cmd.op)
            OP_SQ: m = x_reg * x_reg;
            OP_T1: m = {32'd0, SIN_C} * {32'd0, x2_reg};
            OP_T2: m = {32'd0, x2_reg} * {32'd0, t_reg};
            OP_T3: m = {32'd0, x_reg} * {32'd0, t_reg};
            OP_PROD2:
            begin
                s1 = 45'(pa_reg * qa_reg);
                s2 = 45'(pb_reg * qb_reg);
                ssum = sub ? s1 - s2 : s1 + s2;
                sr = 46'(ssum) + 46'sd134217728;
                qv = 18'(sr >>> 28);
                if (qv > 18'sd16384)       qc = 16'sd16384;
                else if (qv < -18'sd16384) qc = -16'sd16384;
                else                       qc = qv[QW-1:0];
            end
            default: m = '0;
        endcase
    end

    logic [31:0] ts;
    logic [15:0] fv;
    assign ts = 32'(m >> 30);
    assign fv = 16'((ts + 32'd32768) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ang_reg[k] <= '0;
                pos_reg[k] <= '0;
            end
        end
        else if (cmd.op == OP_UPDATE)
        begin
            ang_reg[0] <= step_ang(ang_reg[0], keys_reg[0], keys_reg[1], ainc_reg);
            ang_reg[1] <= step_ang(ang_reg[1], keys_reg[2], keys_reg[3], ainc_reg);
            ang_reg[2] <= step_ang(ang_reg[2], keys_reg[4], keys_reg[5], ainc_reg);
            pos_reg[2] <= step_pos(pos_reg[2], keys_reg[7], keys_reg[6], pinc_reg);
            pos_reg[0] <= step_pos(pos_reg[0], keys_reg[9], keys_reg[8], pinc_reg);
            pos_reg[1] <= step_pos(pos_reg[1], keys_reg[10], keys_reg[11], pinc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            keys_reg <= keys_held;
            dt_reg   <= delta_t;
        end
        unique case (cmd.op)
            OP_INC:
            begin
                ainc_reg <= 24'((rinc + 44'd524288) >> 20);
                pinc_reg <= 24'((tinc + 44'd524288) >> 20);
            end
            OP_TRIG_LD:
            begin
                x_reg   <= {1'b0, u, 8'd0};
                neg_reg <= phase[23];
            end
            OP_SQ: x2_reg <= ts;
            OP_T1: t_reg  <= SIN_B - ts;
            OP_T2: t_reg  <= SIN_A - ts;
            OP_T3: trig_reg[cmd.slot] <= neg_reg ? -$signed(fv) : $signed(fv);
            OP_PROD1:
            begin
                pa_reg <= trig_reg[i1] * trig_reg[i2];
                qa_reg <= trig_reg[i3];
                pb_reg <= trig_reg[i4] * trig_reg[i5];
                qb_reg <= trig_reg[i6];
            end
            OP_PROD2: q_reg[cmd.slot[1:0]] <= qc;
            OP_OUT:
            begin
                qo_reg <= q_reg;
                po_reg <= pos_reg;
            end
            default: ;
        endcase
    end

    assign pos_x  = po_reg[0];
    assign pos_y  = po_reg[1];
    assign pos_z  = po_reg[2];
    assign quat_w = qo_reg[0];
    assign quat_x = qo_reg[1];
    assign quat_y = qo_reg[2];
    assign quat_z = qo_reg[3];
endmodule

// File: bench/kpq_pose_checker.sv
// Checker: watches both channels, predicts each pose item and compares
`timescale 1ns / 1ps
module kpq_pose_checker (
    input  logic        clk,
    input  logic        rst_n,
    kpq_in_if           in_ch,
    kpq_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [kpq_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          pending
);
    import kpq_pkg::*;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } pose_t;

    localparam longint unsigned A_K = 64'd1686629713;
    localparam longint unsigned B_K = 2 * A_K - 64'd2684354560;
    localparam longint unsigned C_K = A_K - 64'd1610612736;

    pose_t           pose_q[$];
    logic [23:0]     rot_rate, trans_rate;
    logic [23:0]     yaw, pitch, roll;
    logic signed [31:0] pos_x, pos_y, pos_z;

    function automatic longint quarter_sin(longint unsigned u);
        longint unsigned x, x2, t;
        x  = u << 8;
        x2 = (x * x) >> 30;
        t  = (C_K * x2) >> 30;
        t  = B_K - t;
        t  = (x2 * t) >> 30;
        t  = A_K - t;
        t  = (x * t) >> 30;
        return longint'((t + 64'd32768) >> 16);
    endfunction

    function automatic longint sin_of(logic [23:0] p);
        logic [1:0]  q;
        logic [21:0] r;
        longint unsigned u;
        longint v;
        q = p[23:22];
        r = p[21:0];
        u = q[0] ? (64'h400000 - r) : r;
        v = quarter_sin(u);
        return q[1] ? -v : v;
    endfunction

    function automatic logic signed [15:0] round_q14(longint s);
        longint v;
        v = (s + (64'sd1 <<< 27)) >>> 28;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return 16'(v);
    endfunction

    function automatic int key_dir(logic [11:0] k, int up, int dn);
        return int'(k[up]) - int'(k[dn]);
    endfunction

    function automatic logic signed [31:0] move_pos(logic signed [31:0] p, int d,
                                                    longint inc);
        longint v;
        v = p + d * inc;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return 32'(v);
    endfunction

    task automatic integrate_keys(logic [11:0] k, logic [19:0] dt);
        longint ainc, pinc, cy, sy, cp, sp, cr, sr;
        pose_t e;
        ainc = (longint'(rot_rate) * dt + (64'sd1 << 19)) >>> 20;
        pinc = (longint'(trans_rate) * dt + (64'sd1 << 19)) >>> 20;
        yaw   = 24'(yaw   + key_dir(k, 0, 1) * ainc);
        pitch = 24'(pitch + key_dir(k, 2, 3) * ainc);
        roll  = 24'(roll  + key_dir(k, 4, 5) * ainc);
        pos_z = move_pos(pos_z, key_dir(k, 7, 6), pinc);
        pos_x = move_pos(pos_x, key_dir(k, 9, 8), pinc);
        pos_y = move_pos(pos_y, key_dir(k, 10, 11), pinc);
        cy = sin_of(yaw + 24'h400000);   sy = sin_of(yaw);
        cr = sin_of(roll + 24'h400000);  sr = sin_of(roll);
        cp = sin_of(pitch + 24'h400000); sp = sin_of(pitch);
        e.px = pos_x; e.py = pos_y; e.pz = pos_z;
        e.qx = round_q14(cy * sr * cp - sy * cr * sp);
        e.qy = round_q14(cy * cr * sp + sy * sr * cp);
        e.qz = round_q14(sy * cr * cp - cy * sr * sp);
        e.qw = round_q14(cy * cr * cp + sy * sr * sp);
        pose_q.push_back(e);
    endtask

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    assign pending = pose_q.size();

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rot_rate   = ROT_RATE_RST;
            trans_rate = TRANS_RATE_RST;
            yaw = '0; pitch = '0; roll = '0;
            pos_x = '0; pos_y = '0; pos_z = '0;
            errors = 0;
            pose_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_ROT_RATE) rot_rate = cfg_data;
                else if (cfg_index == CFG_TRANS_RATE) trans_rate = cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
                integrate_keys(in_ch.keys_held, in_ch.delta_t);
            if (out_ch.valid && out_ch.ready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual px=%0d",
                             $time, out_ch.pos_x);
                    errors++;
                end else begin
                    pose_t e;
                    e = pose_q.pop_front();
                    check_field("pos_x", e.px, out_ch.pos_x);
                    check_field("pos_y", e.py, out_ch.pos_y);
                    check_field("pos_z", e.pz, out_ch.pos_z);
                    check_field("quat_w", e.qw, out_ch.quat_w);
                    check_field("quat_x", e.qx, out_ch.quat_x);
                    check_field("quat_y", e.qy, out_ch.quat_y);
                    check_field("quat_z", e.qz, out_ch.quat_z);
                end
            end
        end
    end
endmodule

// File: bench/keyed_pose_to_quaternion_tb.sv
// Testbench top: stimulus, config phases, stalls and the verdict
`timescale 1ns / 1ps
module keyed_pose_to_quaternion_tb;
    import kpq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CFG_ROT_RATE;
    logic [23:0] cfg_data = '0;
    int          errors, pending;
    int          stall_mode;

    kpq_in_if  in_ch();
    kpq_out_if out_ch();

    keyed_pose_to_quaternion dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    kpq_pose_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.keys_held = '0;
        in_ch.delta_t = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: stall pattern changes per phase; mode 0 never stalls
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // items left in the current burst for bursty sending
    int burst_left = 0;

    // one item: hold valid until taken; gaps only between bursts
    task automatic send_item(logic [11:0] k, logic [19:0] dt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.keys_held <= k;
        in_ch.delta_t <= dt;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic drain_and_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // registers only move while nothing is in flight
    task automatic write_rates(logic [23:0] rot, logic [23:0] trans);
        cfg_we <= 1'b1; cfg_index <= CFG_ROT_RATE; cfg_data <= rot;
        @(posedge clk);
        cfg_index <= CFG_TRANS_RATE; cfg_data <= trans;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly single keys or combos with random dt; some all-random keys
    function automatic logic [11:0] pick_keys();
        case ($urandom_range(0, 3))
            0: return 12'($urandom);
            1: return 12'(1 << $urandom_range(0, 11));
            2: return 12'($urandom) & 12'b0101_0101_0101 | 12'(1 << $urandom_range(0, 11));
            default: return 12'($urandom) & 12'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] pick_dt();
        case ($urandom_range(0, 4))
            0: return 20'hFFFFF;
            1: return 20'($urandom_range(0, 15));
            default: return 20'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [23:0] rot_set[5];
        logic [23:0] trans_set[5];
        stall_mode = 0;
        rot_set   = '{24'd1335089, 24'hFFFFFF, 24'd0, 24'd1, 24'h400000};
        trans_set = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd1, 24'h7FFFFF};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single keys, opposing pairs, zero and max dt
        for (int b = 0; b < 12; b++)
            send_item(12'(1 << b), 20'hFFFFF);
        send_item(12'h000, 20'hFFFFF);
        send_item(12'hFFF, 20'hFFFFF);
        send_item(12'h555, 20'd0);
        send_item(12'hAAA, 20'd1);
        send_item(12'h555, 20'h80000);
        drain_and_idle();

        // drive positions up and down at max rates
        write_rates(24'hFFFFFF, 24'hFFFFFF);
        for (int i = 0; i < 3; i++) send_item(12'h680, 20'hFFFFF);
        for (int i = 0; i < 3; i++) send_item(12'h015, 20'hFFFFF);
        for (int i = 0; i < 5; i++) send_item(12'h940, 20'hFFFFF);
        drain_and_idle();

        // random phases, each under its own rate pair, cycling through the stall patterns
        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 4;
            if (ph < 5) write_rates(rot_set[ph], trans_set[(ph + 2) % 5]);
            else write_rates(24'($urandom), 24'($urandom));
            for (int i = 0; i < 250; i++) send_item(pick_keys(), pick_dt());
            drain_and_idle();
        end

        if (errors == 0)
            $display("keyed_pose_to_quaternion_tb: done, clean");
        else
            $display("keyed_pose_to_quaternion_tb: done, errors");
        $finish;
    end

    // per item: the full sequence plus stalls and gaps; 2028 items run well under 2 ms
    initial
    begin
        #8ms;
        $display("keyed_pose_to_quaternion_tb: done, errors");
        $finish;
    end
endmodule
